// ===== rtl/qesd_pkg.sv =====
`default_nettype none

package qesd_pkg;

    // per-encoder record kept between samples
    typedef struct packed {
        logic [1:0] pair;
        logic [3:0] tally;
        logic       dir;
    } entry_t;

    // signed step from the transition table, -2 to +2
    typedef logic signed [2:0] step_t;

    // movement codes on the result channel
    typedef enum logic [1:0] {
        MOVE_STOPPED = 2'd0,
        MOVE_LEFT    = 2'd1,
        MOVE_RIGHT   = 2'd2
    } move_t;

    localparam logic [3:0] TALLY_RESET = 4'd8;

    localparam entry_t ENTRY_RESET = '{pair: 2'd0, tally: TALLY_RESET, dir: 1'b0};

    // transition table, old pair in bits 3:2 and new pair in bits 1:0
    function automatic step_t step_lookup(input logic [3:0] code);
        step_t s;
        case (code)
            4'd0:    s = 3'sd0;
            4'd1:    s = 3'sd1;
            4'd2:    s = -3'sd1;
            4'd3:    s = 3'sd2;
            4'd4:    s = -3'sd1;
            4'd5:    s = 3'sd0;
            4'd6:    s = -3'sd2;
            4'd7:    s = 3'sd1;
            4'd8:    s = 3'sd1;
            4'd9:    s = -3'sd2;
            4'd10:   s = 3'sd0;
            4'd11:   s = -3'sd1;
            4'd12:   s = 3'sd2;
            4'd13:   s = -3'sd1;
            4'd14:   s = 3'sd1;
            4'd15:   s = 3'sd0;
            default: s = 3'sd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/quadrature_encoder_step_decoder.sv =====
`default_nettype none

// Quadrature step decoder for a bank of rotary encoders. Each item carries an
// encoder index and that encoder's current A/B pin pair; each item gives
// exactly one result, the movement code (stopped, left or right). One item is
// taken every cycle while the result side keeps up. The accepting edge
// registers the item together with a read of the encoder's stored record;
// the edge on which the item advances registers the result while the updated
// record is written back. A result held by the receiver
// stalls the input once both stages are full. Back-to-back items for the same
// encoder see the record just written.
// Per-encoder state starts from its reset value immediately after reset,
// with no clearing pass. Indexes at or above NUM_ENCODERS report stopped and
// leave all state untouched.
module quadrature_encoder_step_decoder #(
    parameter int NUM_ENCODERS      = 32,
    parameter int PULSES_PER_DETENT = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [4:0] encoder_index,
    input  wire logic [1:0] pair_state,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      movement
);
    import qesd_pkg::*;

    localparam int ADDR_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    logic              in_accept;
    logic              in_range;
    logic              s1_adv;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [1:0]        s1_pair_reg;
    logic              s1_range_reg;

    logic              out_valid_reg;
    move_t             movement_reg;
    move_t             movement_next;

    entry_t            old_entry;
    entry_t            new_entry;
    step_t             step;
    logic              step_dir;
    logic [3:0]        tally_sum;
    logic [15:0]       mult_ok;
    logic              moved;

    // tally values that fall on a detent boundary
    for (genvar k = 0; k < 16; k++)
    begin : g_mult
        assign mult_ok[k] = ((k % PULSES_PER_DETENT) == 0);
    end

    // handshake
    assign in_accept = in_valid && in_ready;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_range  = (32'(encoder_index) < NUM_ENCODERS);

    // per-encoder state store
    qesd_state_mem #(
        .NUM_ENCODERS (NUM_ENCODERS),
        .ADDR_W       (ADDR_W)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept && in_range),
        .rd_addr (ADDR_W'(encoder_index)),
        .rd_data (old_entry),
        .wr_en   (s1_adv && s1_range_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (new_entry)
    );

    // step decode and tally update
    always_comb
    begin
        step          = step_lookup({old_entry.pair, s1_pair_reg});
        step_dir      = !step[2];
        tally_sum     = old_entry.tally + {step[2], step};
        moved         = (step != 3'sd0) && (old_entry.dir == step_dir)
                        && mult_ok[tally_sum];
        new_entry     = old_entry;
        new_entry.pair = s1_pair_reg;
        if (step != 3'sd0)
        begin
            new_entry.dir   = step_dir;
            new_entry.tally = moved ? TALLY_RESET : tally_sum;
        end
        if (s1_range_reg && moved)
        begin
            movement_next = step_dir ? MOVE_RIGHT : MOVE_LEFT;
        end
        else
        begin
            movement_next = MOVE_STOPPED;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg  <= ADDR_W'(encoder_index);
            s1_pair_reg  <= pair_state;
            s1_range_reg <= in_range;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            movement_reg <= movement_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign movement  = movement_reg;

endmodule

`default_nettype wire

// ===== rtl/qesd_state_mem.sv =====
`default_nettype none

module qesd_state_mem #(
    parameter int NUM_ENCODERS = 32,
    parameter int ADDR_W       = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output qesd_pkg::entry_t           rd_data,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire qesd_pkg::entry_t      wr_data
);
    import qesd_pkg::*;

    entry_t                  mem [NUM_ENCODERS];
    logic [NUM_ENCODERS-1:0] valid_reg;
    entry_t                  rd_data_reg;

    // entry storage, no reset: unwritten entries read as the reset record
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // written marks, cleared together at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read, a write to the same entry in this cycle is passed on
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= ENTRY_RESET;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
